@@ src/achl_pkg.sv @@
package achl_pkg;

  localparam int BUFFER_BYTES_DEF  = 16384;
  localparam int SCAN_LENGTH_RESET = 16384;
  localparam int CFG_W             = 15;
  localparam int KIND_W            = 3;
  localparam int OFFSET_W          = 30;
  localparam int WINDOW_BYTES      = 10;

  localparam logic [KIND_W-1:0] KIND_NONE         = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ID3          = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RIFF_DATA    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TAG          = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RIFF_NO_DATA = 3'd4;

  typedef enum logic [1:0] {
    PH_SCAN   = 2'd0,
    PH_SEARCH = 2'd1,
    PH_DONE   = 2'd2
  } achl_phase_t;

  typedef struct packed {
    achl_phase_t phase;
    logic [2:0]  prog;
  } achl_ctrl_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_buffer;
  } achl_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]   header_kind;
    logic [OFFSET_W-1:0] payload_offset;
  } achl_out_t;

endpackage

@@ src/audio_container_header_locator.sv @@
// Each byte passes from the input register through the decode logic to the result register.
// Throughput: one byte per cycle unless a new result must wait on out_stall; marker compares,
// the syncsafe size add and the six-byte "data" matcher all sit between those two registers.
// A byte that yields no result moves on even while a finished result waits on out_stall.
// Reset (synchronous, rst_n low) sets scan_length to 16384 and starts a scan at position 0.
module audio_container_header_locator import achl_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  achl_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output achl_out_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int POS_W     = $clog2(BUFFER_BYTES);
  localparam int LEN_W     = $clog2(BUFFER_BYTES+1);
  localparam int MW        = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int LEN_RESET = (SCAN_LENGTH_RESET < BUFFER_BYTES) ? SCAN_LENGTH_RESET
                                                                : BUFFER_BYTES;

  logic             in_valid_r;
  achl_in_t         in_r;
  logic [7:0]       recent_r [WINDOW_BYTES];
  logic [POS_W-1:0] pos_r;
  achl_ctrl_t       ctrl_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;

  logic             start;
  logic             active;
  logic             fire;
  logic             out_free;
  achl_ctrl_t       ctrl_eff;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] pos_nxt;
  logic [7:0]       win [WINDOW_BYTES];
  logic             res_valid;
  achl_out_t        res;
  achl_ctrl_t       ctrl_nxt;

  // Effective scan length is capped at the buffer size when it is written.
  assign len_nxt = (MW'(cfg_wr_data) > MW'(BUFFER_BYTES)) ? LEN_W'(BUFFER_BYTES)
                                                          : LEN_W'(cfg_wr_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(LEN_RESET);
    end else if (cfg_wr_en) begin
      len_r <= len_nxt;
    end
  end

  // A start flag restarts the scan before this byte is looked at.
  assign start = in_r.start_of_buffer;
  always_comb begin
    ctrl_eff = ctrl_r;
    pos_eff  = pos_r;
    if (start) begin
      ctrl_eff.phase = PH_SCAN;
      ctrl_eff.prog  = 3'd0;
      pos_eff        = '0;
    end
    for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
      win[k] = start ? 8'd0 : recent_r[k+1];
    end
    win[WINDOW_BYTES-1] = in_r.data_byte;
  end

  assign active  = (ctrl_eff.phase == PH_SCAN) || (ctrl_eff.phase == PH_SEARCH);
  assign pos_nxt = pos_eff + POS_W'(1);

  achl_decode #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_decode (
    .ctrl_i     (ctrl_eff),
    .pos_i      (pos_eff),
    .len_i      (len_r),
    .win_i      (win),
    .res_valid_o(res_valid),
    .res_o      (res),
    .ctrl_o     (ctrl_nxt)
  );

  assign fire     = in_valid_r && (!res_valid || out_free);
  assign in_stall = in_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      ctrl_r <= '{phase: PH_SCAN, prog: 3'd0};
    end else if (fire && active) begin
      pos_r  <= pos_nxt;
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && active) begin
      for (int k = 0; k < WINDOW_BYTES; k++) begin
        recent_r[k] <= win[k];
      end
    end
  end

  achl_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_i   (fire && res_valid),
    .data_i   (res),
    .free_o   (out_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |=> ctrl_r.phase == PH_DONE)
    else $error("scan did not finish after its result");

  a_search_prog_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.phase == PH_SEARCH |-> !ctrl_r.prog[2])
    else $error("data matcher left complete while still searching");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(fire && res_valid))
    else $error("result appeared without a decoded request");

  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && (res.header_kind == KIND_NONE ||
                          res.header_kind == KIND_RIFF_NO_DATA)
      |-> res.payload_offset == '0)
    else $error("nonzero offset on a result without payload");

endmodule

@@ src/achl_decode.sv @@
module achl_decode import achl_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  achl_ctrl_t                            ctrl_i,
  input  logic [$clog2(BUFFER_BYTES)-1:0]       pos_i,
  input  logic [$clog2(BUFFER_BYTES+1)-1:0]     len_i,
  input  logic [7:0]                            win_i [WINDOW_BYTES],
  output logic                                  res_valid_o,
  output achl_out_t                             res_o,
  output achl_ctrl_t                            ctrl_o
);

  localparam int LEN_W = $clog2(BUFFER_BYTES+1);
  localparam int CW    = LEN_W + 1;

  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_T = 8'h74;

  function automatic logic [7:0] chunk_byte(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_D;
      2'd1:    c = CH_A;
      2'd2:    c = CH_T;
      default: c = CH_A;
    endcase
    return c;
  endfunction

  // Step of the "data" matcher; a mismatch may still restart on 'd'.
  function automatic logic [2:0] advance_match(input logic [2:0] prog, input logic [7:0] b);
    logic [2:0] n;
    if (b == chunk_byte(prog[1:0])) begin
      n = prog + 3'd1;
    end else if (b == CH_D) begin
      n = 3'd1;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

  logic [CW-1:0]       q_ext;
  logic [CW-1:0]       len_ext;
  logic                in_range;
  logic                is_id3;
  logic                is_riff;
  logic                is_tag;
  logic [OFFSET_W-1:0] id3_size;
  logic [2:0]          search_prog;
  logic [2:0]          riff_prog;
  logic                riff_hit;
  logic [3:0]          riff_hit_at;

  assign q_ext   = CW'(pos_i);
  assign len_ext = CW'(len_i);

  assign in_range = (q_ext >= CW'(9)) && ((q_ext + CW'(2)) <= len_ext);
  assign is_id3   = (win_i[0] == 8'h49) && (win_i[1] == 8'h44) && (win_i[2] == 8'h33);
  assign is_riff  = (win_i[0] == 8'h52) && (win_i[1] == 8'h49) &&
                    (win_i[2] == 8'h46) && (win_i[3] == 8'h46);
  assign is_tag   = (win_i[0] == 8'h54) && (win_i[1] == 8'h41) && (win_i[2] == 8'h47);

  // Syncsafe size: four 7-bit groups that overlap by one bit when the top bit is set.
  assign id3_size = OFFSET_W'({win_i[6], 21'd0}) + OFFSET_W'({win_i[7], 14'd0}) +
                    OFFSET_W'({win_i[8], 7'd0}) + OFFSET_W'(win_i[9]) +
                    (win_i[5][4] ? OFFSET_W'(20) : OFFSET_W'(10));

  assign search_prog = advance_match(ctrl_i.prog, win_i[WINDOW_BYTES-1]);

  // Bytes after "RIFF" that are already in the window go through the matcher at once.
  always_comb begin
    riff_prog   = 3'd0;
    riff_hit    = 1'b0;
    riff_hit_at = 4'd0;
    for (int i = 4; i < WINDOW_BYTES; i++) begin
      if (!riff_hit) begin
        riff_prog = advance_match(riff_prog, win_i[i]);
        if (riff_prog[2]) begin
          riff_hit    = 1'b1;
          riff_hit_at = 4'(i);
        end
      end
    end
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    ctrl_o      = ctrl_i;
    case (ctrl_i.phase)
      PH_SEARCH: begin
        ctrl_o.prog = search_prog;
        if (search_prog[2]) begin
          res_valid_o          = 1'b1;
          res_o.header_kind    = KIND_RIFF_DATA;
          res_o.payload_offset = OFFSET_W'(pos_i) + OFFSET_W'(5);
        end else if ((q_ext + CW'(1)) >= len_ext) begin
          res_valid_o       = 1'b1;
          res_o.header_kind = KIND_RIFF_NO_DATA;
        end
      end
      PH_SCAN: begin
        if (len_i < LEN_W'(11)) begin
          res_valid_o       = 1'b1;
          res_o.header_kind = KIND_NONE;
        end else if (in_range && is_id3) begin
          res_valid_o          = 1'b1;
          res_o.header_kind    = KIND_ID3;
          res_o.payload_offset = id3_size;
        end else if (in_range && is_riff) begin
          if (riff_hit) begin
            res_valid_o          = 1'b1;
            res_o.header_kind    = KIND_RIFF_DATA;
            res_o.payload_offset = OFFSET_W'(pos_i) + OFFSET_W'(riff_hit_at) -
                                   OFFSET_W'(4);
          end else begin
            ctrl_o.phase = PH_SEARCH;
            ctrl_o.prog  = riff_prog;
          end
        end else if (in_range && is_tag) begin
          res_valid_o          = 1'b1;
          res_o.header_kind    = KIND_TAG;
          res_o.payload_offset = OFFSET_W'(128);
        end else if ((q_ext + CW'(2)) >= len_ext) begin
          res_valid_o       = 1'b1;
          res_o.header_kind = KIND_NONE;
        end
      end
      default: begin
      end
    endcase
    if (res_valid_o) begin
      ctrl_o.phase = PH_DONE;
    end
  end

endmodule

@@ src/achl_out_reg.sv @@
module achl_out_reg import achl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load_i,
  input  achl_out_t data_i,
  output logic      free_o,
  output logic      out_valid,
  input  logic      out_stall,
  output achl_out_t out_data
);

  logic      valid_r;
  achl_out_t data_r;

  assign free_o    = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free_o) begin
      valid_r <= load_i;
    end
  end

  always_ff @(posedge clk) begin
    if (free_o && load_i) begin
      data_r <= data_i;
    end
  end

endmodule

@@ verif/achl_offset_checker.sv @@
module achl_offset_checker import achl_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  achl_in_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  achl_out_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [23:0] ID3_MARK      = 24'h494433;
  localparam logic [31:0] RIFF_MARK     = 32'h52494646;
  localparam logic [31:0] DATA_MARK     = 32'h64617461;
  localparam logic [23:0] TAG_MARK      = 24'h544147;
  localparam logic [7:0]  ID3_FOOTER    = 8'h10;
  localparam int          TAG_OFFSET    = 128;

  logic [CFG_W-1:0] scan_len = CFG_W'(SCAN_LENGTH_RESET);
  logic [7:0]       window [WINDOW_BYTES];
  int               byte_pos;
  achl_phase_t      phase;
  logic [2:0]       chunk_prog;
  achl_out_t        expected_q [$];
  int               fail_count = 0;
  int               backlog = 0;

  assign errors  = fail_count;
  assign pending = backlog;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic restart_scan();
    byte_pos   = 0;
    phase      = PH_SCAN;
    chunk_prog = 3'd0;
    for (int i = 0; i < WINDOW_BYTES; i++) window[i] = 8'h00;
  endtask

  // Progress of the "data" matcher; a mismatching 'd' restarts the match at one byte.
  function automatic logic [2:0] chunk_step(input logic [2:0] prog, input logic [7:0] b);
    if (b == DATA_MARK[31 - 8 * prog[1:0] -: 8]) return prog + 3'd1;
    return (b == DATA_MARK[31:24]) ? 3'd1 : 3'd0;
  endfunction

  task automatic push_result(input logic [KIND_W-1:0] kind, input logic [31:0] offset);
    achl_out_t res;
    res.header_kind    = kind;
    res.payload_offset = offset[OFFSET_W-1:0];
    expected_q.push_back(res);
    phase = PH_DONE;
  endtask

  task automatic predict_byte(input achl_in_t req);
    int          eff;
    int          q;
    int          p;
    logic [31:0] size;
    logic [2:0]  prog;
    if (req.start_of_buffer) restart_scan();
    if (phase != PH_SCAN && phase != PH_SEARCH) return;

    eff = (scan_len > BUFFER_BYTES) ? BUFFER_BYTES : int'(scan_len);
    q = byte_pos;
    byte_pos++;
    for (int i = 0; i < WINDOW_BYTES - 1; i++) window[i] = window[i + 1];
    window[WINDOW_BYTES - 1] = req.data_byte;

    if (phase == PH_SEARCH) begin
      chunk_prog = chunk_step(chunk_prog, req.data_byte);
      if (chunk_prog >= 3'd4) push_result(KIND_RIFF_DATA, q + 5);
      else if (q >= eff - 1) push_result(KIND_RIFF_NO_DATA, 0);
      return;
    end

    if (eff < 11) begin
      push_result(KIND_NONE, 0);
      return;
    end

    // A marker at p is judged once the byte at p+9 is in the window.
    if (q >= 9 && q <= eff - 2) begin
      p = q - 9;
      if ({window[0], window[1], window[2]} == ID3_MARK) begin
        size = (32'(window[6]) << 21) + (32'(window[7]) << 14) +
               (32'(window[8]) << 7) + 32'(window[9]);
        if ((window[5] & ID3_FOOTER) != 8'h00) size += 10;
        push_result(KIND_ID3, size + 10);
        return;
      end
      if ({window[0], window[1], window[2], window[3]} == RIFF_MARK) begin
        prog = 3'd0;
        for (int i = 4; i < WINDOW_BYTES; i++) begin
          prog = chunk_step(prog, window[i]);
          if (prog >= 3'd4) begin
            push_result(KIND_RIFF_DATA, p + i + 5);
            return;
          end
        end
        chunk_prog = prog;
        phase      = PH_SEARCH;
        return;
      end
      if ({window[0], window[1], window[2]} == TAG_MARK) begin
        push_result(KIND_TAG, TAG_OFFSET);
        return;
      end
    end
    if (q >= eff - 2) push_result(KIND_NONE, 0);
  endtask

  task automatic check_result(input achl_out_t got);
    achl_out_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d offset %0d",
                                got.header_kind, got.payload_offset));
      return;
    end
    want = expected_q.pop_front();
    if (got.header_kind !== want.header_kind) begin
      report_mismatch($sformatf("header_kind %0d, expected %0d",
                                got.header_kind, want.header_kind));
    end
    if (got.payload_offset !== want.payload_offset) begin
      report_mismatch($sformatf("payload_offset %0d, expected %0d",
                                got.payload_offset, want.payload_offset));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_scan();
      scan_len = CFG_W'(SCAN_LENGTH_RESET);
      expected_q.delete();
    end else begin
      if (cfg_wr_en) scan_len = cfg_wr_data;
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) predict_byte(in_data);
    end
    backlog = expected_q.size();
  end

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import achl_pkg::*;

  localparam int          CLK_HALF      = 4;
  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          RANDOM_ITEMS  = 1300;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          BUFS_PER_LEN  = 30;
  localparam logic [23:0] ID3_MARK      = 24'h494433;
  localparam logic [31:0] RIFF_MARK     = 32'h52494646;
  localparam logic [31:0] DATA_MARK     = 32'h64617461;
  localparam logic [23:0] TAG_MARK      = 24'h544147;
  localparam logic [95:0] HOT_BYTES     = 96'h49_44_33_52_46_54_41_47_64_61_74_10;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  achl_in_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  achl_out_t        out_data;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  int               fail_count;
  int               backlog;
  int               cycles = 0;
  int               random_items = 0;
  bit               quiet = 1'b0;
  logic [CFG_W-1:0] scan_len_now = CFG_W'(SCAN_LENGTH_RESET);
  logic [7:0]       buf_q [$];

  audio_container_header_locator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  achl_offset_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (fail_count),
    .pending     (backlog)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("audio_container_header_locator verification failed");
      $finish;
    end
  end

  // Result side: hold off a random number of cycles before taking each result.
  initial begin : result_backpressure
    int hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 15);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_req(input logic [7:0] b, input logic sob);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid                  <= 1'b1;
    in_data.data_byte         <= b;
    in_data.start_of_buffer   <= sob;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_buf(input bit with_start);
    foreach (buf_q[i]) send_req(buf_q[i], with_start && (i == 0));
  endtask

  // Wait until every expected result is out and the pipeline has emptied.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_scan_length(input logic [CFG_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    scan_len_now = v;
  endtask

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, 255));
    return HOT_BYTES[8 * $urandom_range(0, 11) +: 8];
  endfunction

  task automatic fill_noise(input int n);
    buf_q.delete();
    repeat (n) buf_q.push_back(noise_byte());
  endtask

  task automatic fill_zero(input int n);
    buf_q.delete();
    repeat (n) buf_q.push_back(8'h00);
  endtask

  task automatic put_at(input int at, input logic [31:0] word, input int nb);
    for (int i = 0; i < nb; i++) begin
      if (at + i < buf_q.size()) buf_q[at + i] = word[8 * (nb - 1 - i) +: 8];
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_scan_length();
    case ($urandom_range(0, 9))
      0:       return CFG_W'($urandom_range(0, 10));
      1:       return CFG_W'(11);
      2:       return CFG_W'($urandom_range(BUFFER_BYTES_DEF, (1 << CFG_W) - 1));
      3:       return CFG_W'($urandom_range(61, BUFFER_BYTES_DEF - 1));
      default: return CFG_W'($urandom_range(12, 60));
    endcase
  endfunction

  task automatic random_buffer();
    int eff;
    int span;
    int n;
    int m;
    int d;
    bit with_start;
    eff  = (scan_len_now > BUFFER_BYTES_DEF) ? BUFFER_BYTES_DEF : int'(scan_len_now);
    span = (eff < 11) ? 4 : ((eff > 60) ? 60 : eff);
    n = span + $urandom_range(0, 6);
    if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
    fill_noise(n);
    // Markers land on both sides of the last scanned position.
    m = $urandom_range(0, (span > 8) ? span - 8 : 0);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        put_at(m, ID3_MARK, 3);
        if ($urandom_range(0, 3) == 0) put_at(m + 6, 32'hFFFF_FFFF, 4);
      end
      3, 4, 5: begin
        put_at(m, RIFF_MARK, 4);
        if ($urandom_range(0, 3) != 0) begin
          d = m + 4 + $urandom_range(0, span);
          put_at(d, DATA_MARK, 4);
        end
      end
      6:       put_at(m, TAG_MARK, 3);
      7:       put_at(m, RIFF_MARK >> 8, 3);
      default: ;
    endcase
    quiet      = ($urandom_range(0, 5) == 0);
    with_start = ($urandom_range(0, 9) != 0);
    send_buf(with_start);
    random_items += n;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Right after reset the block scans even without a start flag.
    fill_zero(12);
    put_at(0, ID3_MARK, 3);
    buf_q[5] = 8'h10;
    put_at(6, 32'hFFFF_FFFF, 4);
    send_buf(1'b0);

    fill_zero(10);
    put_at(0, TAG_MARK, 3);
    send_buf(1'b1);

    fill_zero(10);
    put_at(0, RIFF_MARK, 4);
    put_at(4, DATA_MARK, 4);
    send_buf(1'b1);

    fill_zero(10);
    put_at(0, ID3_MARK, 3);
    buf_q[5] = 8'hEF;
    send_buf(1'b1);

    // "data" found by the running search, well after the RIFF marker.
    fill_zero(16);
    put_at(0, RIFF_MARK, 4);
    put_at(12, DATA_MARK, 4);
    send_buf(1'b1);

    // Lengths below eleven report nothing found on the first byte.
    set_scan_length(CFG_W'(0));
    fill_zero(2);
    send_buf(1'b1);
    set_scan_length(CFG_W'(10));
    fill_zero(1);
    send_buf(1'b1);

    // Shortest real scan: only position zero is examined.
    set_scan_length(CFG_W'(11));
    fill_zero(11);
    put_at(0, RIFF_MARK, 4);
    send_buf(1'b1);
    fill_zero(10);
    put_at(0, RIFF_MARK, 4);
    put_at(6, DATA_MARK, 4);
    send_buf(1'b1);
    fill_zero(10);
    send_buf(1'b1);

    // Length cut while scanning, then while searching for the data chunk.
    set_scan_length(CFG_W'(64));
    fill_zero(20);
    send_buf(1'b1);
    set_scan_length(CFG_W'(12));
    fill_zero(1);
    send_buf(1'b0);
    set_scan_length(CFG_W'(64));
    fill_zero(14);
    put_at(0, RIFF_MARK, 4);
    send_buf(1'b1);
    set_scan_length(CFG_W'(14));
    fill_zero(1);
    send_buf(1'b0);

    while (random_items < RANDOM_ITEMS) begin
      set_scan_length(pick_scan_length());
      repeat (BUFS_PER_LEN) begin
        if (random_items < RANDOM_ITEMS) random_buffer();
      end
    end

    set_scan_length(CFG_W'(SCAN_LENGTH_RESET));
    repeat (BUFS_PER_LEN / 3) random_buffer();
    settle();

    if (fail_count == 0) begin
      $display("audio_container_header_locator verification clean");
    end else begin
      $display("audio_container_header_locator verification failed");
    end
    $finish;
  end

endmodule
